// ===== rtl/cbd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and defaults for the chunked core bit dequantiser.
package cbd_pkg;

    localparam int MAX_CHUNKS_DEF  = 64;
    localparam int WINDOW_BITS_DEF = 64;

    localparam int CHUNK_NUM_W = 7;
    localparam int WIDTH_W     = 5;
    localparam int VALUE_W     = 32;
    localparam int QUO_W       = 32;

    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FEW_BITS  = 2'd1;
    localparam logic [1:0] ST_BAD_CHUNK = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]             mode;
        logic [7:0]             stream_byte;
        logic [CHUNK_NUM_W-1:0] chunk_number;
        logic [WIDTH_W-1:0]     chunk_bits;
        logic signed [31:0]     chunk_low;
        logic signed [31:0]     chunk_high;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
    } t_out_item;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [31:0]        low;
        logic [31:0]        high;
    } t_chunk_entry;

    typedef struct packed {
        logic               start;
        logic [30:0]        mag;
        logic [31:0]        span_abs;
        logic               span_neg;
        logic [WIDTH_W-1:0] width;
    } t_scale_req;

    typedef struct packed {
        logic        done;
        logic [32:0] quot;
    } t_scale_rsp;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_CHECK,
        CS_WAIT,
        CS_FIX,
        CS_RESULT
    } t_ctrl_state;

    typedef enum logic [1:0] {
        US_IDLE,
        US_MUL,
        US_DIV,
        US_DONE
    } t_unit_state;

endpackage

// ===== rtl/cbd_scale_unit.sv =====
`timescale 1ns / 1ps
// Multiply then restoring divide by 2^q-1, one quotient bit per cycle.
module cbd_scale_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cbd_pkg::t_scale_req i_req,
    output cbd_pkg::t_scale_rsp o_rsp
);

    localparam int CNT_W = $clog2(cbd_pkg::QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(cbd_pkg::QUO_W - 1);

    cbd_pkg::t_unit_state r_state;
    cbd_pkg::t_unit_state n_state;

    logic [30:0]      r_mag;
    logic [31:0]      r_span;
    logic             r_neg;
    logic [30:0]      r_div;
    logic [30:0]      r_rem;
    logic [31:0]      r_quo;
    logic [CNT_W-1:0] r_cnt;

    logic [62:0] w_prod;
    logic [31:0] w_trial;
    logic        w_take;
    logic [31:0] w_diff;

    assign w_prod  = 63'(r_mag) * 63'(r_span);
    assign w_trial = {r_rem, r_quo[31]};
    assign w_take  = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_state = r_state;
        case (r_state)
            cbd_pkg::US_IDLE: begin
                if (i_req.start) begin
                    n_state = cbd_pkg::US_MUL;
                end
            end
            cbd_pkg::US_MUL:  n_state = cbd_pkg::US_DIV;
            cbd_pkg::US_DIV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = cbd_pkg::US_DONE;
                end
            end
            cbd_pkg::US_DONE: n_state = cbd_pkg::US_IDLE;
            default:          n_state = cbd_pkg::US_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == cbd_pkg::US_DONE);
        o_rsp.quot = r_neg ? (33'd0 - {1'b0, r_quo}) : {1'b0, r_quo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbd_pkg::US_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cbd_pkg::US_IDLE: begin
                if (i_req.start) begin
                    r_mag  <= i_req.mag;
                    r_span <= i_req.span_abs;
                    r_neg  <= i_req.span_neg;
                    r_div  <= (31'(1) << i_req.width) - 31'(1);
                end
            end
            cbd_pkg::US_MUL: begin
                // The product is below divisor * 2^32, so its top half is a valid remainder.
                r_rem <= w_prod[62:32];
                r_quo <= w_prod[31:0];
                r_cnt <= '0;
            end
            cbd_pkg::US_DIV: begin
                r_rem <= w_take ? w_diff[30:0] : w_trial[30:0];
                r_quo <= {r_quo[30:0], w_take};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    a_start_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == cbd_pkg::US_IDLE)
        else $error("scale unit started while busy");

    a_rem_below_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cbd_pkg::US_DIV |-> r_rem < r_div)
        else $error("division remainder not below divisor");

    a_done_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !o_rsp.done)
        else $error("done held for more than one cycle");

endmodule

// ===== rtl/chunked_core_bit_dequantizer_top.sv =====
`timescale 1ns / 1ps
// Top level of the chunked core bit dequantiser: bit window, chunk table and sequencer.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+---------------------------
//  input    | in        | i_in_valid / o_in_ready   | i_in  (cbd_pkg::t_in_item)
//  output   | out       | o_out_valid / i_out_ready | o_out (cbd_pkg::t_out_item)
//
// Push, load and every rejected transaction finish in the cycle they are accepted, so
// such transactions may follow one another every cycle while the output drains.
// A decode that reaches the arithmetic passes, from acceptance to the next
// acceptance, through one table read, one multiply and 32 restoring-divider steps in the
// scale unit, then a sum, a saturating negation and the output load.
// A decode of a chunk of width zero, or one with too few bits, skips the scale unit.
// Reset (synchronous, active low) empties the window; the chunk table holds no
// defined contents until loaded. A stalled output holds the block in its result state.
module chunked_core_bit_dequantizer_top #(
    parameter int MAX_CHUNKS  = cbd_pkg::MAX_CHUNKS_DEF,
    parameter int WINDOW_BITS = cbd_pkg::WINDOW_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cbd_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cbd_pkg::t_out_item o_out
);

    localparam int HELD_W = $clog2(WINDOW_BITS + 1);
    localparam int HW1    = HELD_W + 1;
    localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int NUM_W  = cbd_pkg::CHUNK_NUM_W + 2;

    cbd_pkg::t_ctrl_state r_state;
    cbd_pkg::t_ctrl_state n_state;

    logic [WINDOW_BITS-1:0] r_window;
    logic [HELD_W-1:0]      r_held;

    // Chunk table: one entry written per load with a valid chunk number, read on every acceptance.
    cbd_pkg::t_chunk_entry r_table [MAX_CHUNKS];
    cbd_pkg::t_chunk_entry r_entry;

    logic               r_out_valid;
    cbd_pkg::t_out_item r_out;
    cbd_pkg::t_out_item r_res;
    logic               r_neg;
    logic [33:0]        r_sum;

    logic               w_accept;
    logic               w_slot_free;
    logic               w_in_ready;
    logic               w_load_res;
    logic [NUM_W-1:0]   w_num;
    logic [NUM_W-1:0]   w_num_m1;
    logic [IDX_W-1:0]   w_idx;
    logic               w_chunk_ok;
    logic               w_full;
    cbd_pkg::t_out_item w_imm;
    logic               w_imm_done;

    logic [cbd_pkg::WIDTH_W-1:0] w_q;
    logic                        w_few;
    logic [HELD_W-1:0]           w_shift;
    logic [WINDOW_BITS-1:0]      w_shifted;
    logic [31:0]                 w_fld;
    logic [30:0]                 w_mag;
    logic [32:0]                 w_span;
    logic [32:0]                 w_span_neg_val;
    logic                        w_start;
    logic [31:0]                 w_v;
    logic [31:0]                 w_final;

    cbd_pkg::t_scale_req w_req;
    cbd_pkg::t_scale_rsp w_rsp;

    assign w_accept    = i_in_valid && w_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Chunk numbers are 1-based; zero and anything beyond the table are rejected.
    assign w_num      = NUM_W'(i_in.chunk_number);
    assign w_num_m1   = w_num - NUM_W'(1);
    assign w_idx      = w_num_m1[IDX_W-1:0];
    assign w_chunk_ok = (i_in.chunk_number != '0) && (w_num <= NUM_W'(MAX_CHUNKS));
    assign w_full     = (HW1'(r_held) + HW1'(8)) > HW1'(WINDOW_BITS);

    // Result of a transaction that completes on acceptance.
    always_comb begin
        w_imm      = '0;
        w_imm_done = 1'b1;
        case (i_in.mode)
            cbd_pkg::MODE_PUSH: begin
                if (w_full) begin
                    w_imm.status = cbd_pkg::ST_FULL;
                end
            end
            cbd_pkg::MODE_LOAD: begin
                if (!w_chunk_ok) begin
                    w_imm.status = cbd_pkg::ST_BAD_CHUNK;
                end
            end
            cbd_pkg::MODE_DECODE: begin
                if (!w_chunk_ok) begin
                    w_imm.status = cbd_pkg::ST_BAD_CHUNK;
                end else begin
                    w_imm_done = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Field extraction: a sign bit followed by a q-bit magnitude, taken from the
    // oldest bits still held in the window.
    assign w_q       = r_entry.width;
    assign w_few     = r_held < (HELD_W'(w_q) + HELD_W'(1));
    assign w_shift   = r_held - HELD_W'(w_q) - HELD_W'(1);
    assign w_shifted = r_window >> w_shift;
    assign w_fld     = w_shifted[31:0];
    assign w_mag     = w_fld[30:0] & ((31'(1) << w_q) - 31'(1));

    assign w_span         = {r_entry.high[31], r_entry.high} - {r_entry.low[31], r_entry.low};
    assign w_span_neg_val = 33'd0 - w_span;

    assign w_req.start    = w_start;
    assign w_req.mag      = w_mag;
    assign w_req.span_neg = w_span[32];
    assign w_req.span_abs = w_span[32] ? w_span_neg_val[31:0] : w_span[31:0];
    assign w_req.width    = w_q;

    // The value lies between the two limits, so the low 32 bits of the sum are exact.
    assign w_v     = r_sum[31:0];
    assign w_final = !r_neg ? w_v
                   : (w_v == 32'h8000_0000) ? 32'h7FFF_FFFF
                   : (32'd0 - w_v);

    cbd_scale_unit u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            cbd_pkg::CS_IDLE: begin
                if (w_accept && !w_imm_done) begin
                    n_state = cbd_pkg::CS_CHECK;
                end
            end
            cbd_pkg::CS_CHECK: begin
                if ((w_q == '0) || w_few) begin
                    n_state = cbd_pkg::CS_RESULT;
                end else begin
                    n_state = cbd_pkg::CS_WAIT;
                end
            end
            cbd_pkg::CS_WAIT: begin
                if (w_rsp.done) begin
                    n_state = cbd_pkg::CS_FIX;
                end
            end
            cbd_pkg::CS_FIX:    n_state = cbd_pkg::CS_RESULT;
            cbd_pkg::CS_RESULT: begin
                if (w_slot_free) begin
                    n_state = cbd_pkg::CS_IDLE;
                end
            end
            default:            n_state = cbd_pkg::CS_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = (r_state == cbd_pkg::CS_IDLE) && w_slot_free;
        w_start    = (r_state == cbd_pkg::CS_CHECK) && (w_q != '0) && !w_few;
        w_load_res = (r_state == cbd_pkg::CS_RESULT) && w_slot_free;
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbd_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_held   <= '0;
        end else if (w_accept && (i_in.mode == cbd_pkg::MODE_PUSH) && !w_full) begin
            r_window <= {r_window[WINDOW_BITS-9:0], i_in.stream_byte};
            r_held   <= r_held + HELD_W'(8);
        end else if (w_start) begin
            r_held <= w_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in.mode == cbd_pkg::MODE_LOAD) && w_chunk_ok) begin
            r_table[w_idx] <= {i_in.chunk_bits, i_in.chunk_low, i_in.chunk_high};
        end
        if (w_accept) begin
            r_entry <= r_table[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cbd_pkg::CS_CHECK: begin
                if (w_q == '0) begin
                    r_res.status <= cbd_pkg::ST_OK;
                    r_res.value  <= r_entry.low;
                end else if (w_few) begin
                    r_res.status <= cbd_pkg::ST_FEW_BITS;
                    r_res.value  <= '0;
                end
                r_neg <= w_fld[w_q];
            end
            cbd_pkg::CS_WAIT: begin
                if (w_rsp.done) begin
                    r_sum <= {w_rsp.quot[32], w_rsp.quot}
                           + {{2{r_entry.low[31]}}, r_entry.low};
                end
            end
            cbd_pkg::CS_FIX: begin
                r_res.status <= cbd_pkg::ST_OK;
                r_res.value  <= w_final;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_accept && w_imm_done) || w_load_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_imm_done) begin
            r_out <= w_imm;
        end else if (w_load_res) begin
            r_out <= r_res;
        end
    end

    a_held_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HELD_W'(WINDOW_BITS))
        else $error("bit count exceeds window size");

    a_push_adds_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.mode == cbd_pkg::MODE_PUSH) && !w_full)
        |=> r_held == $past(r_held) + HELD_W'(8))
        else $error("accepted push did not add eight bits");

    a_decode_consumes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> r_held < $past(r_held))
        else $error("decode started without consuming bits");

    a_done_in_wait : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == cbd_pkg::CS_WAIT)
        else $error("scale unit finished outside the wait state");

endmodule
